// File: sv/token_bucket_pool_macros.svh
`ifndef TOKEN_BUCKET_POOL_MACROS_SVH
`define TOKEN_BUCKET_POOL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("token bucket pool: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("token bucket pool: next-cycle check failed");

`endif

// File: sv/tbp_pkg.sv
`default_nettype none

package tbp_pkg;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int AMOUNT_W = 16;
    localparam int GRANT_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FETCH   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GIVE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

    typedef enum logic {
        ALU_ADD_CAP = 1'b0,
        ALU_SUB_MIN = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] amount;
        logic [AMOUNT_W-1:0] rate;
        logic [AMOUNT_W-1:0] burst;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic [GRANT_W-1:0]  granted;
        logic [STATUS_W-1:0] status;
    } t_rsp;

endpackage

`default_nettype wire

// File: sv/tbp_if.sv
`default_nettype none

interface tbp_req_if;
    import tbp_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbp_rsp_if;
    import tbp_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/tbp_mem.sv
`default_nettype none

module tbp_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 49
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/tbp_alu.sv
`default_nettype none

module tbp_alu #(
    parameter int TOKEN_BITS = 16
) (
    input  wire tbp_pkg::t_alu_op         i_op,
    input  wire logic [TOKEN_BITS-1:0]    i_tokens,
    input  wire logic [((TOKEN_BITS > tbp_pkg::AMOUNT_W) ?
                        TOKEN_BITS : tbp_pkg::AMOUNT_W)-1:0] i_operand,
    input  wire logic [TOKEN_BITS-1:0]    i_limit,
    output logic      [TOKEN_BITS-1:0]    o_tokens,
    output logic      [tbp_pkg::GRANT_W-1:0] o_granted
);
    import tbp_pkg::*;

    localparam int OPND_W = (TOKEN_BITS > AMOUNT_W) ? TOKEN_BITS : AMOUNT_W;
    localparam int SUM_W  = OPND_W + 1;

    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] cap;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] take;
    logic [SUM_W-1:0] res;

    assign a    = SUM_W'(i_tokens);
    assign b    = SUM_W'(i_operand);
    assign cap  = SUM_W'(i_limit);
    assign sum  = a + b;
    assign take = (a < b) ? a : b;

    always_comb begin
        case (i_op)
            ALU_ADD_CAP: res = (sum > cap) ? cap : sum;
            ALU_SUB_MIN: res = a - take;
            default:     res = a;
        endcase
    end

    // Both results are bounded by the limit or the current count, so they fit.
    assign o_tokens  = TOKEN_BITS'(res);
    assign o_granted = GRANT_W'(take);

endmodule

`default_nettype wire

// File: sv/token_bucket_pool.sv
// Fetch, give back and release: the accepted beat reads its slot, passes through S_EXEC and
// loads its result into the output register. Tick and allocate walk the memory one entry per cycle.
// Fetch, give back or release to an out-of-range slot, and unknown modes, finish in S_IDLE unread.
// The bucket memory has one read and one write port and a registered read.
// A finished item waits in S_DONE while the output register still holds an unaccepted beat.
// After reset a clearing pass in S_CLEAR frees every slot; ready stays low meanwhile.
`default_nettype none

module token_bucket_pool #(
    parameter int SLOTS      = 64,
    parameter int TOKEN_BITS = 16
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    tbp_req_if.sink   i_req,
    tbp_rsp_if.source o_rsp
);
    import tbp_pkg::*;

`include "token_bucket_pool_macros.svh"

    localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OPND_W = (TOKEN_BITS > AMOUNT_W) ? TOKEN_BITS : AMOUNT_W;
    localparam int CMP_W  = OPND_W + 1;
    localparam int DW     = 3 * TOKEN_BITS + 1;

    typedef struct packed {
        logic                  in_use;
        logic [TOKEN_BITS-1:0] rate;
        logic [TOKEN_BITS-1:0] limit;
        logic [TOKEN_BITS-1:0] tokens;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WALK  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    t_req    r_req;
    t_rsp    r_res;
    t_rsp    r_rsp;
    logic    r_out_valid;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata;
    logic [DW-1:0] mem_rdata;
    t_entry        rd;

    t_alu_op             alu_op;
    logic [OPND_W-1:0]   alu_b;
    logic [TOKEN_BITS-1:0] alu_tok;
    logic [GRANT_W-1:0]  alu_grant;

    logic [TOKEN_BITS-1:0] clamp_rate, clamp_burst;
    logic    fin, out_free, last_idx, accept;
    logic    fetch_acc, tick_step;
    t_rsp    res;

    assign rd       = mem_rdata;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign last_idx = (r_idx == IW'(SLOTS - 1));
    assign accept   = i_req.valid && i_req.ready;

    assign fetch_acc = accept && (i_req.data.mode == MODE_FETCH)
                     && (32'(i_req.data.slot) < SLOTS);
    assign tick_step = (r_state == S_WALK) && (r_req.mode == MODE_TICK) && !last_idx;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Rate and burst saturate when the bucket fields are narrower than the inputs.
    assign clamp_rate  = (CMP_W'(r_req.rate) > CMP_W'({TOKEN_BITS{1'b1}}))
                       ? {TOKEN_BITS{1'b1}} : TOKEN_BITS'(r_req.rate);
    assign clamp_burst = (CMP_W'(r_req.burst) > CMP_W'({TOKEN_BITS{1'b1}}))
                       ? {TOKEN_BITS{1'b1}} : TOKEN_BITS'(r_req.burst);

    tbp_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IW),
        .DATA_W (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tbp_alu #(
        .TOKEN_BITS (TOKEN_BITS)
    ) u_alu (
        .i_op      (alu_op),
        .i_tokens  (rd.tokens),
        .i_operand (alu_b),
        .i_limit   (rd.limit),
        .o_tokens  (alu_tok),
        .o_granted (alu_grant)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = rd;
        mem_re       = 1'b0;
        mem_raddr    = r_idx;
        alu_op       = ALU_ADD_CAP;
        alu_b        = OPND_W'(rd.rate);
        fin          = 1'b0;
        res.slot_out = r_req.slot;
        res.granted  = '0;
        res.status   = ST_OK;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (last_idx) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                res.slot_out = i_req.data.slot;
                if (i_req.valid) begin
                    unique case (i_req.data.mode) inside
                        MODE_TICK, MODE_ALLOC: begin
                            n_idx     = '0;
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_state   = S_WALK;
                        end
                        MODE_FETCH, MODE_GIVE, MODE_RELEASE: begin
                            if (32'(i_req.data.slot) < SLOTS) begin
                                mem_re    = 1'b1;
                                mem_raddr = IW'(i_req.data.slot);
                                n_state   = S_EXEC;
                            end else begin
                                fin        = 1'b1;
                                res.status = ST_UNUSED;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_req.mode == MODE_TICK) begin
                    if (rd.in_use) begin
                        mem_we           = 1'b1;
                        mem_wdata.tokens = alu_tok;
                    end
                    if (last_idx) begin
                        fin = 1'b1;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + 1'b1;
                    end
                end else if (!rd.in_use) begin
                    mem_we           = 1'b1;
                    mem_wdata.in_use = 1'b1;
                    mem_wdata.rate   = clamp_rate;
                    mem_wdata.limit  = clamp_burst;
                    mem_wdata.tokens = '0;
                    fin              = 1'b1;
                    res.slot_out     = SLOT_W'(r_idx);
                end else if (last_idx) begin
                    fin          = 1'b1;
                    res.status   = ST_FULL;
                    res.slot_out = '0;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + 1'b1;
                end
            end
            S_EXEC: begin
                fin       = 1'b1;
                mem_waddr = IW'(r_req.slot);
                alu_b     = OPND_W'(r_req.amount);
                case (r_req.mode)
                    MODE_FETCH: begin
                        alu_op = ALU_SUB_MIN;
                        if (!rd.in_use) begin
                            res.status = ST_UNUSED;
                        end else if (rd.tokens == '0) begin
                            res.status = ST_EMPTY;
                        end else begin
                            res.granted      = alu_grant;
                            mem_we           = 1'b1;
                            mem_wdata.tokens = alu_tok;
                        end
                    end
                    MODE_GIVE: begin
                        if (!rd.in_use) begin
                            res.status = ST_UNUSED;
                        end else begin
                            mem_we           = 1'b1;
                            mem_wdata.tokens = alu_tok;
                        end
                    end
                    MODE_RELEASE: begin
                        if (!rd.in_use) begin
                            res.status = ST_UNUSED;
                        end else begin
                            mem_we           = 1'b1;
                            mem_wdata.in_use = 1'b0;
                        end
                    end
                    default: begin
                        res.status = ST_OK;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished beat goes straight to the output register when it is free.
        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if ((fin || (r_state == S_DONE)) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.data;
        end
        if (fin && !out_free) begin
            r_res <= res;
        end
        if (fin && out_free) begin
            r_rsp <= res;
        end else if ((r_state == S_DONE) && out_free) begin
            r_rsp <= r_res;
        end
    end

    `TBP_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, mem_we && mem_re, mem_waddr != mem_raddr)
    `TBP_ASSERT_NEXT(a_fetch_reads, i_clk, i_rst_n, fetch_acc, r_state == S_EXEC)
    `TBP_ASSERT_NOW(a_grant_ok, i_clk, i_rst_n, r_out_valid && (r_rsp.granted != '0), r_rsp.status == ST_OK)
    `TBP_ASSERT_NEXT(a_tick_walks, i_clk, i_rst_n, tick_step, r_state == S_WALK)

endmodule

`default_nettype wire
